FILE: hw/rtl/adll_pkg.sv
// Package for the array-backed doubly linked list.
// Request codes, status codes, record type. No dependencies.
package adll_pkg;
   localparam int SLOTS_DEF = 16;
   typedef enum logic [3:0] {
      REQ_ADDFIRST = 4'd0, REQ_ADDAFTER = 4'd1, REQ_ADDLAST = 4'd2,
      REQ_DELFIRST = 4'd3, REQ_DELAFTER = 4'd4, REQ_DELLAST = 4'd5,
      REQ_DELALL = 4'd6, REQ_SORT = 4'd7, REQ_READ = 4'd8
   } req_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_BAD = 2'd3
   } status_type;
   localparam int REC_W = 8 + 64 + 16 + 20;
   typedef struct packed {
      logic [19:0] price;
      logic [15:0] stock;
      logic [63:0] name;
      logic [7:0]  number;
   } rec_type;
endpackage

FILE: hw/rtl/array_doubly_linked_list.sv
// Doubly linked list held in a fixed slot store.
// Uses adll_pkg and adll_ram (record memory, link memory).
//
// Usage: one request beat enters on req_* (tdata fields from bit 0: slot_index,
// item_number, item_name, stock_count, unit_price; tuser carries req_type).
// One response beat leaves on rsp_* for every request. The block works on one
// request at a time: req_tready is high only while the sequencer is idle.
// Requests answered by a status check alone take the shortest path; reads and
// single inserts/deletes also wait on the registered read data of the record
// and link memories and on the read-modify-write of up to three link words.
// Delete all clears one link pair per cycle. Sort walks the list with an
// exchange sort: n*(n-1)/2 compared pairs, each with or without an exchange.
// The next request is taken in the cycle after the response beat.
// The lowest free slot comes from a priority encoder over busy flags.
// Reset clears busy flags, head, tail and count; memory contents are left.
// A held response stalls the block: no new request is taken until the
// response beat is accepted.
module array_doubly_linked_list
   import adll_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slot_index[3:0], item_number[11:4], item_name[75:12],
   // stock_count[91:76], unit_price[111:92]
   input  logic [111:0] req_tdata,
   // req_type[3:0]
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // used_slot[3:0], entry_count[8:4], head_slot[13:9], tail_slot[18:14],
   // read_number[26:19], read_name[90:27], read_stock[106:91],
   // read_price[126:107], read_prev[131:127], read_next[136:132]
   output logic [143:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);
   localparam int AW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 2);
   localparam logic [LW-1:0] NONE = LW'(SLOTS);
   localparam logic [LW-1:0] FREE = LW'(SLOTS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RD1, S_RD1W, S_DO1, S_RD2W, S_DO2, S_WRX, S_CLR,
      S_SP, S_SPW, S_SN, S_SNW, S_SCMP, S_SW1, S_SNXT, S_SNXTW, S_SPNXTW,
      S_RSP
   } state_type;

   state_type        state_ff;
   logic [SLOTS-1:0] busy_ff;
   logic [LW-1:0]    head_ff, tail_ff;
   logic [LW-1:0]    count_ff;
   logic [3:0]       op_ff;
   logic [3:0]       idx_ff;
   rec_type          inrec_ff;
   logic [AW-1:0]    s_ff, h_ff, a_ff;
   logic [LW-1:0]    n_ff;
   logic [AW:0]      clr_ff;
   rec_type          prec_ff;
   logic [LW-1:0]    pnext_ff;
   logic [1:0]       st_ff;
   logic [3:0]       used_ff;
   rec_type          rrec_ff;
   logic [LW-1:0]    rprev_ff, rnext_ff;

   // record memory
   logic          rw_en;
   logic [AW-1:0] rw_addr, rr_addr;
   rec_type       rw_data, rr_data;
   // link memory {prev,next}
   logic            lw_en;
   logic [AW-1:0]   lw_addr, lr_addr;
   logic [2*LW-1:0] lw_data, lr_data;
   logic [LW-1:0]   lr_prev, lr_next;

   adll_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec (
      .clock, .wr_en(rw_en), .wr_addr(rw_addr), .wr_data(rw_data),
      .rd_addr(rr_addr), .rd_data(rr_data));
   adll_ram #(.WIDTH(2*LW), .DEPTH(SLOTS)) u_lnk (
      .clock, .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
      .rd_addr(lr_addr), .rd_data(lr_data));
   assign lr_prev = lr_data[2*LW-1:LW];
   assign lr_next = lr_data[LW-1:0];

   logic [AW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) free_slot = AW'(i);
      end
   end

   logic full, idx_ok;
   assign full   = (count_ff == LW'(SLOTS));
   assign idx_ok = ({1'b0, idx_ff} < 5'(SLOTS)) && busy_ff[AW'(idx_ff)];

   // second pending link write (registered) for add-after and delete-after
   logic            x_en_ff;
   logic [AW-1:0]   x_addr_ff;
   logic [2*LW-1:0] x_data_ff;

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      rw_en  <= 1'b0;
      lw_en  <= 1'b0;
      if (reset) begin
         state_ff   <= S_IDLE;
         busy_ff    <= '0;
         head_ff    <= NONE;
         tail_ff    <= NONE;
         count_ff   <= '0;
         rsp_tvalid <= 1'b0;
         x_en_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff           <= req_tuser;
                  idx_ff          <= req_tdata[3:0];
                  inrec_ff.number <= req_tdata[11:4];
                  inrec_ff.name   <= req_tdata[75:12];
                  inrec_ff.stock  <= req_tdata[91:76];
                  inrec_ff.price  <= req_tdata[111:92];
                  st_ff    <= ST_OK;
                  used_ff  <= '0;
                  rrec_ff  <= '0;
                  rprev_ff <= '0;
                  rnext_ff <= '0;
                  x_en_ff  <= 1'b0;
                  state_ff <= S_RD1;
               end
            end
            S_RD1: begin
               s_ff <= free_slot;
               state_ff <= S_RSP;
               unique case (op_ff)
                  REQ_ADDFIRST, REQ_ADDLAST: begin
                     if (full) st_ff <= ST_FULL;
                     else state_ff <= S_DO1;
                  end
                  REQ_ADDAFTER, REQ_DELAFTER: begin
                     if (op_ff == REQ_ADDAFTER && full) st_ff <= ST_FULL;
                     else if (op_ff == REQ_DELAFTER && head_ff == NONE)
                        st_ff <= ST_EMPTY;
                     else if (!idx_ok) st_ff <= ST_BAD;
                     else begin
                        lr_addr <= AW'(idx_ff);
                        state_ff <= S_RD1W;
                     end
                  end
                  REQ_DELFIRST, REQ_DELLAST: begin
                     if (head_ff == NONE) st_ff <= ST_EMPTY;
                     else begin
                        lr_addr <= (op_ff == REQ_DELFIRST) ? AW'(head_ff) : AW'(tail_ff);
                        state_ff <= S_RD1W;
                     end
                  end
                  REQ_DELALL: begin
                     clr_ff <= '0;
                     state_ff <= S_CLR;
                  end
                  REQ_SORT: begin
                     if (head_ff != NONE) begin
                        a_ff <= AW'(head_ff);
                        state_ff <= S_SP;
                     end
                  end
                  REQ_READ: begin
                     if ({1'b0, idx_ff} >= 5'(SLOTS)) st_ff <= ST_BAD;
                     else if (!busy_ff[AW'(idx_ff)]) begin
                        rprev_ff <= FREE;
                        rnext_ff <= FREE;
                     end else begin
                        lr_addr <= AW'(idx_ff);
                        rr_addr <= AW'(idx_ff);
                        state_ff <= S_RD1W;
                     end
                  end
                  default: ;
               endcase
            end
            S_RD1W: state_ff <= S_DO1;
            S_DO1: begin
               state_ff <= S_RSP;
               unique case (op_ff)
                  REQ_ADDFIRST, REQ_ADDLAST: begin
                     busy_ff[s_ff] <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                     used_ff  <= 4'(s_ff);
                     rw_en <= 1'b1; rw_addr <= s_ff; rw_data <= inrec_ff;
                     lw_en <= 1'b1; lw_addr <= s_ff;
                     if (op_ff == REQ_ADDFIRST) begin
                        lw_data <= {NONE, head_ff};
                        head_ff <= LW'(s_ff);
                        if (head_ff == NONE) tail_ff <= LW'(s_ff);
                        else begin
                           lr_addr <= AW'(head_ff);
                           h_ff <= AW'(head_ff);
                           state_ff <= S_RD2W;
                        end
                     end else begin
                        lw_data <= {tail_ff, NONE};
                        tail_ff <= LW'(s_ff);
                        if (tail_ff == NONE) head_ff <= LW'(s_ff);
                        else begin
                           lr_addr <= AW'(tail_ff);
                           h_ff <= AW'(tail_ff);
                           state_ff <= S_RD2W;
                        end
                     end
                  end
                  REQ_ADDAFTER: begin
                     busy_ff[s_ff] <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                     used_ff  <= 4'(s_ff);
                     rw_en <= 1'b1; rw_addr <= s_ff; rw_data <= inrec_ff;
                     lw_en <= 1'b1; lw_addr <= s_ff;
                     lw_data <= {LW'(idx_ff), lr_next};
                     x_en_ff <= 1'b1; x_addr_ff <= AW'(idx_ff);
                     x_data_ff <= {lr_prev, LW'(s_ff)};
                     if (lr_next == NONE) tail_ff <= LW'(s_ff);
                     else begin
                        n_ff <= lr_next;
                        h_ff <= AW'(lr_next);
                        lr_addr <= AW'(lr_next);
                        state_ff <= S_RD2W;
                     end
                     if (lr_next == NONE) state_ff <= S_WRX;
                  end
                  REQ_DELFIRST: begin
                     h_ff <= AW'(head_ff);
                     used_ff <= 4'(head_ff);
                     busy_ff[AW'(head_ff)] <= 1'b0;
                     count_ff <= count_ff - 1'b1;
                     lw_en <= 1'b1; lw_addr <= AW'(head_ff); lw_data <= {FREE, FREE};
                     if (lr_next == NONE) begin
                        head_ff <= NONE; tail_ff <= NONE;
                     end else begin
                        head_ff <= lr_next;
                        lr_addr <= AW'(lr_next);
                        h_ff <= AW'(lr_next);
                        state_ff <= S_RD2W;
                     end
                  end
                  REQ_DELLAST: begin
                     used_ff <= 4'(tail_ff);
                     busy_ff[AW'(tail_ff)] <= 1'b0;
                     count_ff <= count_ff - 1'b1;
                     lw_en <= 1'b1; lw_addr <= AW'(tail_ff); lw_data <= {FREE, FREE};
                     if (lr_prev == NONE) begin
                        head_ff <= NONE; tail_ff <= NONE;
                     end else begin
                        tail_ff <= lr_prev;
                        lr_addr <= AW'(lr_prev);
                        h_ff <= AW'(lr_prev);
                        state_ff <= S_RD2W;
                     end
                  end
                  REQ_DELAFTER: begin
                     if (lr_next == NONE) st_ff <= ST_BAD;
                     else begin
                        pnext_ff <= lr_prev;
                        h_ff <= AW'(lr_next);
                        lr_addr <= AW'(lr_next);
                        state_ff <= S_RD2W;
                     end
                  end
                  REQ_READ: begin
                     rrec_ff  <= rr_data;
                     rprev_ff <= lr_prev;
                     rnext_ff <= lr_next;
                  end
                  default: ;
               endcase
            end
            S_RD2W: state_ff <= S_DO2;
            S_DO2: begin
               state_ff <= S_RSP;
               lw_en <= 1'b1;
               lw_addr <= h_ff;
               unique case (op_ff)
                  REQ_ADDFIRST: lw_data <= {LW'(s_ff), lr_next};
                  REQ_ADDLAST:  lw_data <= {lr_prev, LW'(s_ff)};
                  REQ_ADDAFTER: lw_data <= {LW'(s_ff), lr_next};
                  REQ_DELFIRST: lw_data <= {NONE, lr_next};
                  REQ_DELLAST:  lw_data <= {lr_prev, NONE};
                  REQ_DELAFTER: begin
                     // h_ff is the victim; relink anchor and successor
                     lw_data <= {FREE, FREE};
                     used_ff <= 4'(h_ff);
                     busy_ff[h_ff] <= 1'b0;
                     count_ff <= count_ff - 1'b1;
                     x_en_ff <= 1'b1; x_addr_ff <= AW'(idx_ff);
                     x_data_ff <= {pnext_ff, lr_next};
                     if (lr_next == NONE) begin
                        tail_ff <= LW'(idx_ff);
                        state_ff <= S_WRX;
                     end else begin
                        n_ff <= lr_next;
                        a_ff <= AW'(lr_next);
                        lr_addr <= AW'(lr_next);
                        state_ff <= S_SPNXTW;
                     end
                  end
                  default: ;
               endcase
               if (op_ff == REQ_ADDAFTER) state_ff <= S_WRX;
            end
            S_SPNXTW: state_ff <= S_SNXTW;
            S_SNXTW: begin
               // successor of deleted entry: prev <- anchor
               lw_en <= 1'b1; lw_addr <= a_ff;
               lw_data <= {LW'(idx_ff), lr_next};
               state_ff <= S_WRX;
            end
            S_WRX: begin
               if (x_en_ff) begin
                  lw_en <= 1'b1; lw_addr <= x_addr_ff; lw_data <= x_data_ff;
               end
               x_en_ff <= 1'b0;
               state_ff <= S_RSP;
            end
            S_CLR: begin
               lw_en <= 1'b1; lw_addr <= clr_ff[AW-1:0]; lw_data <= {FREE, FREE};
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(SLOTS - 1)) begin
                  busy_ff <= '0; count_ff <= '0;
                  head_ff <= NONE; tail_ff <= NONE;
                  state_ff <= S_RSP;
               end
            end
            // sort: outer a_ff, inner h_ff
            S_SP: begin
               rr_addr <= a_ff; lr_addr <= a_ff;
               state_ff <= S_SPW;
            end
            S_SPW: state_ff <= S_SN;
            S_SN: begin
               prec_ff <= rr_data;
               pnext_ff <= lr_next;
               if (lr_next == NONE) state_ff <= S_RSP;
               else begin
                  h_ff <= AW'(lr_next);
                  rr_addr <= AW'(lr_next); lr_addr <= AW'(lr_next);
                  state_ff <= S_SNW;
               end
            end
            S_SNW: state_ff <= S_SCMP;
            S_SCMP: begin
               n_ff <= lr_next;
               state_ff <= S_SNXT;
               if (prec_ff.price < rr_data.price) begin
                  rw_en <= 1'b1; rw_addr <= h_ff; rw_data <= prec_ff;
                  prec_ff <= rr_data;
                  state_ff <= S_SW1;
               end
            end
            S_SW1: begin
               rw_en <= 1'b1; rw_addr <= a_ff; rw_data <= prec_ff;
               state_ff <= S_SNXT;
            end
            S_SNXT: begin
               if (n_ff == NONE) begin
                  a_ff <= AW'(pnext_ff);
                  state_ff <= S_SP;
               end else begin
                  h_ff <= AW'(n_ff);
                  rr_addr <= AW'(n_ff); lr_addr <= AW'(n_ff);
                  state_ff <= S_SNW;
               end
            end
            S_RSP: begin
               if (!rsp_tvalid) rsp_tvalid <= 1'b1;
               else if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tuser = st_ff;
   assign rsp_tdata = {7'd0, 5'(rnext_ff), 5'(rprev_ff), rrec_ff.price, rrec_ff.stock,
                       rrec_ff.name, rrec_ff.number, 5'(tail_ff), 5'(head_ff),
                       5'(count_ff), used_ff};
endmodule

FILE: hw/rtl/adll_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module adll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sim/array_doubly_linked_list_test.sv
// Self-checking testbench for array_doubly_linked_list: directed and random
// list requests, each response checked field by field against a local predictor.
// Depends on adll_pkg and the array_doubly_linked_list RTL.
module array_doubly_linked_list_test;
   import adll_pkg::*;

   localparam int NSLOT = SLOTS_DEF;
   localparam logic [4:0] LNK_NONE = 5'(NSLOT);
   localparam logic [4:0] LNK_FREE = 5'(NSLOT + 1);
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      bit          drain;
      logic [3:0]  code;
      logic [3:0]  idx;
      rec_type     rec;
   } op_type;

   typedef struct {
      status_type  status;
      logic [3:0]  used;
      logic [4:0]  count;
      logic [4:0]  head;
      logic [4:0]  tail;
      rec_type     rec;
      logic [4:0]  prv;
      logic [4:0]  nxt;
   } reply_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [3:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   array_doubly_linked_list DUT (.*);

   op_type     pending[$];
   reply_type  replies_due[$];
   op_type     on_bus;
   int      sent = 0;
   int      seen = 0;
   int      errors = 0;
   int      cycles = 0;
   int      hold_cnt = 0;
   bit      hold_done = 0;

   // shadow of the list
   bit         busy[NSLOT];
   logic [4:0] nxt_l[NSLOT];
   logic [4:0] prv_l[NSLOT];
   rec_type    store[NSLOT];
   logic [4:0] head_p, tail_p, live;

   function automatic logic [4:0] lowest_free();
      for (int i = 0; i < NSLOT; i++) if (!busy[i]) return 5'(i);
      return '0;
   endfunction

   function automatic logic [4:0] claim(rec_type r);
      logic [4:0] s;
      s = lowest_free();
      busy[s[3:0]] = 1;
      store[s[3:0]] = r;
      live++;
      return s;
   endfunction

   function automatic void release_slot(logic [4:0] s);
      busy[s[3:0]] = 0;
      nxt_l[s[3:0]] = LNK_FREE;
      prv_l[s[3:0]] = LNK_FREE;
      live--;
   endfunction

   function automatic reply_type apply_request(op_type o);
      reply_type  y;
      logic [4:0] s, h, n, p, a;
      rec_type    t;
      a = {1'b0, o.idx};
      y = '{status: ST_OK, used: '0, count: '0, head: '0, tail: '0, rec: '0,
            prv: '0, nxt: '0};
      case (o.code)
         REQ_ADDFIRST: begin
            if (live >= 5'(NSLOT)) y.status = ST_FULL;
            else begin
               s = claim(o.rec);
               prv_l[s[3:0]] = LNK_NONE;
               nxt_l[s[3:0]] = head_p;
               if (head_p == LNK_NONE) tail_p = s;
               else prv_l[head_p[3:0]] = s;
               head_p = s;
               y.used = s[3:0];
            end
         end
         REQ_ADDAFTER: begin
            if (live >= 5'(NSLOT)) y.status = ST_FULL;
            else if (!busy[o.idx]) y.status = ST_BAD;
            else begin
               s = claim(o.rec);
               n = nxt_l[o.idx];
               prv_l[s[3:0]] = a;
               nxt_l[s[3:0]] = n;
               nxt_l[o.idx] = s;
               if (n == LNK_NONE) tail_p = s;
               else prv_l[n[3:0]] = s;
               y.used = s[3:0];
            end
         end
         REQ_ADDLAST: begin
            if (live >= 5'(NSLOT)) y.status = ST_FULL;
            else begin
               s = claim(o.rec);
               nxt_l[s[3:0]] = LNK_NONE;
               prv_l[s[3:0]] = tail_p;
               if (tail_p == LNK_NONE) head_p = s;
               else nxt_l[tail_p[3:0]] = s;
               tail_p = s;
               y.used = s[3:0];
            end
         end
         REQ_DELFIRST: begin
            if (head_p == LNK_NONE) y.status = ST_EMPTY;
            else begin
               h = head_p;
               n = nxt_l[h[3:0]];
               if (n == LNK_NONE) begin
                  head_p = LNK_NONE;
                  tail_p = LNK_NONE;
               end else begin
                  prv_l[n[3:0]] = LNK_NONE;
                  head_p = n;
               end
               release_slot(h);
               y.used = h[3:0];
            end
         end
         REQ_DELAFTER: begin
            if (head_p == LNK_NONE) y.status = ST_EMPTY;
            else if (!busy[o.idx] || nxt_l[o.idx] == LNK_NONE) y.status = ST_BAD;
            else begin
               h = nxt_l[o.idx];
               n = nxt_l[h[3:0]];
               nxt_l[o.idx] = n;
               if (n == LNK_NONE) tail_p = a;
               else prv_l[n[3:0]] = a;
               release_slot(h);
               y.used = h[3:0];
            end
         end
         REQ_DELLAST: begin
            if (tail_p == LNK_NONE) y.status = ST_EMPTY;
            else begin
               h = tail_p;
               p = prv_l[h[3:0]];
               if (p == LNK_NONE) begin
                  head_p = LNK_NONE;
                  tail_p = LNK_NONE;
               end else begin
                  nxt_l[p[3:0]] = LNK_NONE;
                  tail_p = p;
               end
               release_slot(h);
               y.used = h[3:0];
            end
         end
         REQ_DELALL: begin
            for (int i = 0; i < NSLOT; i++) begin
               busy[i] = 0;
               nxt_l[i] = LNK_FREE;
               prv_l[i] = LNK_FREE;
            end
            live = '0;
            head_p = LNK_NONE;
            tail_p = LNK_NONE;
         end
         REQ_SORT: begin
            for (p = head_p; p < LNK_NONE; p = nxt_l[p[3:0]])
               for (n = nxt_l[p[3:0]]; n < LNK_NONE; n = nxt_l[n[3:0]])
                  if (store[p[3:0]].price < store[n[3:0]].price) begin
                     t = store[p[3:0]];
                     store[p[3:0]] = store[n[3:0]];
                     store[n[3:0]] = t;
                  end
         end
         REQ_READ: begin
            if (busy[o.idx]) begin
               y.rec = store[o.idx];
               y.prv = prv_l[o.idx];
               y.nxt = nxt_l[o.idx];
            end else begin
               y.prv = LNK_FREE;
               y.nxt = LNK_FREE;
            end
         end
         default: ;
      endcase
      y.count = live;
      y.head = head_p;
      y.tail = tail_p;
      return y;
   endfunction

   task automatic report_mismatch(string fld, logic [63:0] got, logic [63:0] want);
      $display("mismatch on response %0d: %s got %0h expected %0h", seen, fld, got, want);
      errors++;
   endtask

   // 0: sender 15% idle, receiver 88%; 1: swapped; 2: no idling
   function automatic int pace();
      return sent < 150 ? 0 : (sent < 300 ? 1 : 2);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      bit gap;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_request(on_bus));
            sent <= sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && pending[0].drain && replies_due.size() == 0)
               void'(pending.pop_front());
            gap = pace() == 0 ? $urandom_range(99) < 15 :
                  pace() == 1 ? $urandom_range(99) < 88 : 0;
            if (pending.size() > 0 && !pending[0].drain && !gap) begin
               on_bus = pending.pop_front();
               req_tvalid <= 1;
               req_tuser <= on_bus.code;
               req_tdata <= {on_bus.rec.price, on_bus.rec.stock, on_bus.rec.name,
                             on_bus.rec.number, on_bus.idx};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // long receiver hold-off once traffic is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (seen == 60 && !hold_done) begin
         hold_cnt <= 500;
         hold_done <= 1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type w;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("unexpected beat", 64'd1, 64'd0);
            end else begin
               w = replies_due.pop_front();
               if (rsp_tuser != w.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(w.status));
               if (rsp_tdata[3:0] != w.used)
                  report_mismatch("used_slot", 64'(rsp_tdata[3:0]), 64'(w.used));
               if (rsp_tdata[8:4] != w.count)
                  report_mismatch("entry_count", 64'(rsp_tdata[8:4]), 64'(w.count));
               if (rsp_tdata[13:9] != w.head)
                  report_mismatch("head_slot", 64'(rsp_tdata[13:9]), 64'(w.head));
               if (rsp_tdata[18:14] != w.tail)
                  report_mismatch("tail_slot", 64'(rsp_tdata[18:14]), 64'(w.tail));
               if (rsp_tdata[26:19] != w.rec.number)
                  report_mismatch("read_number", 64'(rsp_tdata[26:19]), 64'(w.rec.number));
               if (rsp_tdata[90:27] != w.rec.name)
                  report_mismatch("read_name", rsp_tdata[90:27], w.rec.name);
               if (rsp_tdata[106:91] != w.rec.stock)
                  report_mismatch("read_stock", 64'(rsp_tdata[106:91]), 64'(w.rec.stock));
               if (rsp_tdata[126:107] != w.rec.price)
                  report_mismatch("read_price", 64'(rsp_tdata[126:107]), 64'(w.rec.price));
               if (rsp_tdata[131:127] != w.prv)
                  report_mismatch("read_prev", 64'(rsp_tdata[131:127]), 64'(w.prv));
               if (rsp_tdata[136:132] != w.nxt)
                  report_mismatch("read_next", 64'(rsp_tdata[136:132]), 64'(w.nxt));
            end
            seen <= seen + 1;
         end
         rsp_tready <= hold_cnt == 0 &&
                       !(pace() == 0 ? $urandom_range(99) < 88 :
                         pace() == 1 ? $urandom_range(99) < 15 : 0);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("array_doubly_linked_list regression: fail");
         $finish;
      end
   end

   function automatic rec_type rand_rec();
      rec_type r;
      r.number = 8'($urandom);
      r.name = {$urandom, $urandom};
      r.stock = 16'($urandom);
      r.price = 20'($urandom);
      return r;
   endfunction

   task automatic queue_op(logic [3:0] code, logic [3:0] idx, rec_type r);
      pending.push_back('{drain: 0, code: code, idx: idx, rec: r});
   endtask

   task automatic queue_drain();
      pending.push_back('{drain: 1, code: REQ_SORT, idx: 0, rec: '0});
   endtask

   initial begin
      int w;
      logic [3:0] c;
      head_p = LNK_NONE;
      tail_p = LNK_NONE;
      live = '0;
      foreach (busy[i]) busy[i] = 0;
      // empty list cases
      queue_op(REQ_DELFIRST, 4'd0, rand_rec());
      queue_op(REQ_DELLAST, 4'd0, rand_rec());
      queue_op(REQ_DELAFTER, 4'd0, rand_rec());
      queue_op(REQ_SORT, 4'd0, rand_rec());
      queue_op(REQ_DELALL, 4'd0, rand_rec());
      queue_op(REQ_READ, 4'd15, rand_rec());
      // field extremes
      queue_op(REQ_ADDLAST, 4'd15, '1);
      queue_op(REQ_ADDFIRST, 4'd0, '0);
      queue_op(REQ_ADDAFTER, 4'd1, rand_rec());
      queue_op(REQ_ADDAFTER, 4'd9, rand_rec());
      queue_op(REQ_READ, 4'd0, rand_rec());
      queue_op(REQ_READ, 4'd2, rand_rec());
      queue_op(REQ_DELAFTER, 4'd0, rand_rec());
      queue_op(REQ_DELAFTER, 4'd9, rand_rec());
      queue_op(REQ_SORT, 4'd0, rand_rec());
      queue_op(REQ_READ, 4'd1, rand_rec());
      queue_op(REQ_DELAFTER, 4'd1, rand_rec());
      queue_op(REQ_DELLAST, 4'd0, rand_rec());
      queue_op(REQ_DELFIRST, 4'd0, rand_rec());
      queue_op(4'(int'(REQ_READ) + 1), 4'd0, rand_rec());
      queue_op(4'hF, 4'd0, rand_rec());
      queue_op(REQ_DELALL, 4'd0, rand_rec());
      queue_drain();
      // random: segments lean toward filling or draining the list
      for (int seg = 0; seg < 15; seg++) begin
         for (int k = 0; k < 28; k++) begin
            w = $urandom_range(99);
            if (seg % 2 == 0)
               c = w < 25 ? REQ_ADDLAST : w < 45 ? REQ_ADDFIRST : w < 70 ? REQ_ADDAFTER :
                   w < 80 ? REQ_READ : w < 86 ? REQ_DELAFTER : w < 90 ? REQ_DELFIRST :
                   w < 93 ? REQ_DELLAST : w < 96 ? REQ_SORT : w < 98 ? REQ_DELALL :
                   4'($urandom_range(15, int'(REQ_READ) + 1));
            else
               c = w < 15 ? REQ_DELFIRST : w < 30 ? REQ_DELLAST : w < 50 ? REQ_DELAFTER :
                   w < 70 ? REQ_READ : w < 80 ? REQ_SORT : w < 90 ? REQ_ADDAFTER :
                   w < 96 ? REQ_ADDLAST : REQ_DELALL;
            queue_op(c, 4'($urandom_range(15)), rand_rec());
         end
         if (seg == 7) queue_drain();
      end
      repeat (6) @(posedge clock);
      reset <= 0;
      wait (pending.size() == 0 && !req_tvalid && replies_due.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && replies_due.size() == 0) begin
         $display("array_doubly_linked_list regression: pass");
      end else begin
         $display("array_doubly_linked_list regression: fail");
      end
      $finish;
   end
endmodule
